// ===== hdl/qolm_pkg.sv =====
// qolm_pkg: shared types, register map, fixed-point constants and the
// microprogram of the observer / lqr / mixer sequencer.
// no dependencies; used by the top level, qolm_mul and qolm_rf.
package qolm_pkg;

  localparam int unsigned PC_W     = 8;
  localparam int unsigned PROG_LEN = 152;

  typedef enum logic [2:0] {
    OP_LD, OP_KLD, OP_ADD, OP_SUB, OP_MUL, OP_MUL20, OP_MOT, OP_END
  } op_e;

  typedef logic [5:0] ra_t;

  // register file map
  localparam ra_t R_E0  = 6'd0;
  localparam ra_t R_E1  = 6'd1;
  localparam ra_t R_E2  = 6'd2;
  localparam ra_t R_E3  = 6'd3;
  localparam ra_t R_E4  = 6'd4;
  localparam ra_t R_E5  = 6'd5;
  localparam ra_t R_E6  = 6'd6;
  localparam ra_t R_E7  = 6'd7;
  localparam ra_t R_E8  = 6'd8;
  localparam ra_t R_H0  = 6'd9;
  localparam ra_t R_H1  = 6'd10;
  localparam ra_t R_H2  = 6'd11;
  localparam ra_t R_H3  = 6'd12;
  localparam ra_t R_H4  = 6'd13;
  localparam ra_t R_H5  = 6'd14;
  localparam ra_t R_H6  = 6'd15;
  localparam ra_t R_H7  = 6'd16;
  localparam ra_t R_H8  = 6'd17;
  localparam ra_t R_PRR = 6'd18;
  localparam ra_t R_PPR = 6'd19;
  localparam ra_t R_GX  = 6'd20;
  localparam ra_t R_GY  = 6'd21;
  localparam ra_t R_GZ  = 6'd22;
  localparam ra_t R_AZ  = 6'd23;
  localparam ra_t R_TGX = 6'd24;
  localparam ra_t R_TGY = 6'd25;
  localparam ra_t R_TGZ = 6'd26;
  localparam ra_t R_ZR  = 6'd27;  // never written, always reads zero
  localparam ra_t R_WX  = 6'd28;
  localparam ra_t R_WY  = 6'd29;
  localparam ra_t R_WZ  = 6'd30;
  localparam ra_t R_AZG = 6'd31;
  localparam ra_t R_TQX = 6'd32;
  localparam ra_t R_TQY = 6'd33;
  localparam ra_t R_ENX = 6'd34;
  localparam ra_t R_ENY = 6'd35;
  localparam ra_t R_ER  = 6'd36;
  localparam ra_t R_EPX = 6'd37;
  localparam ra_t R_EPY = 6'd38;
  localparam ra_t R_EPZ = 6'd39;
  localparam ra_t R_EPS = 6'd40;
  localparam ra_t R_ETH = 6'd41;
  localparam ra_t R_EPH = 6'd42;
  localparam ra_t R_D0  = 6'd43;
  localparam ra_t R_D1  = 6'd44;
  localparam ra_t R_D2  = 6'd45;
  localparam ra_t R_D3  = 6'd46;
  localparam ra_t R_D4  = 6'd47;
  localparam ra_t R_D5  = 6'd48;
  localparam ra_t R_D6  = 6'd49;
  localparam ra_t R_D7  = 6'd50;
  localparam ra_t R_D8  = 6'd51;
  localparam ra_t R_T0  = 6'd52;
  localparam ra_t R_T1  = 6'd53;
  localparam ra_t R_TCX = 6'd54;
  localparam ra_t R_TCY = 6'd55;
  localparam ra_t R_TZ  = 6'd56;
  localparam ra_t R_FZ  = 6'd57;
  localparam ra_t R_KA  = 6'd58;
  localparam ra_t R_KB  = 6'd59;
  localparam ra_t R_KC  = 6'd60;

  // input field selectors for OP_LD
  localparam ra_t FLD_GX = 6'd0;
  localparam ra_t FLD_GY = 6'd1;
  localparam ra_t FLD_GZ = 6'd2;
  localparam ra_t FLD_AZ = 6'd3;
  localparam ra_t FLD_TX = 6'd4;
  localparam ra_t FLD_TY = 6'd5;
  localparam ra_t FLD_TZ = 6'd6;

  // motor selectors for OP_MOT
  localparam ra_t MOT_1 = 6'd0;
  localparam ra_t MOT_2 = 6'd1;
  localparam ra_t MOT_3 = 6'd2;
  localparam ra_t MOT_4 = 6'd3;

  typedef enum logic [5:0] {
    K_NONE, K_D2R, K_G, K_NG, K_JX, K_JY, K_FLOW,
    K_00, K_01, K_02, K_10, K_11, K_12, K_20, K_21, K_30,
    K_40, K_41, K_42, K_50, K_51, K_52, K_60, K_61, K_62,
    K_70, K_71, K_72, K_80, K_81, K_DT,
    K_C0, K_C1, K_C2, K_C3, K_C4,
    K_Y0, K_Y1, K_Y2, K_Y3, K_Y4,
    K_Z0, K_Z1, K_F0, K_F1, K_F2,
    K_MA, K_MC, K_MF
  } kc_e;

  typedef struct packed {
    op_e  op;
    ra_t  dst;
    ra_t  a;
    ra_t  b;
    kc_e  k;
  } instr_t;

  // multiplier handshake
  typedef struct packed {
    logic start;
    logic sh20;
  } mul_ctl_t;

  localparam longint P20 = 64'sd1048576;
  localparam longint E12 = 64'sd1000000000000;
  localparam longint E9  = 64'sd1000000000;
  localparam longint E8  = 64'sd100000000;
  localparam longint E5  = 64'sd100000;
  localparam longint E3  = 64'sd1000;
  localparam longint E2  = 64'sd100;
  localparam longint E1  = 64'sd10;

  // round(n/d * 2^40), evaluated in two 20-bit halves
  localparam longint Q_D2R = ((64'sd17453292520*P20/E12)*P20)
    + ((((64'sd17453292520*P20)%E12)*P20 + E12/2)/E12);
  localparam longint Q_G = ((64'sd981*P20/E2)*P20)
    + ((((64'sd981*P20)%E2)*P20 + E2/2)/E2);
  localparam longint Q_JX = ((64'sd665*P20/E5)*P20)
    + ((((64'sd665*P20)%E5)*P20 + E5/2)/E5);
  localparam longint Q_JY = ((64'sd9*P20/E3)*P20)
    + ((((64'sd9*P20)%E3)*P20 + E3/2)/E3);
  localparam longint Q_FLOW = ((64'sd409255568*P20/E8)*P20)
    + ((((64'sd409255568*P20)%E8)*P20 + E8/2)/E8);
  localparam longint Q_00 = -(((64'sd942602196*P20/E12)*P20)
    + ((((64'sd942602196*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_01 = -(((64'sd16404197470*P20/E9)*P20)
    + ((((64'sd16404197470*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_02 = -(((64'sd209967346900*P20/E12)*P20)
    + ((((64'sd209967346900*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_10 = -(((64'sd472454219*P20/E12)*P20)
    + ((((64'sd472454219*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_11 = -(((64'sd19284667266*P20/E9)*P20)
    + ((((64'sd19284667266*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_12 = ((64'sd168166039618*P20/E12)*P20)
    + ((((64'sd168166039618*P20)%E12)*P20 + E12/2)/E12);
  localparam longint Q_20 = -(((64'sd28475040222*P20/E9)*P20)
    + ((((64'sd28475040222*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_21 = -(((64'sd53582500769*P20/E9)*P20)
    + ((((64'sd53582500769*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_30 = -(((64'sd10326989768*P20/E9)*P20)
    + ((((64'sd10326989768*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_40 = -(((64'sd2176067045*P20/E12)*P20)
    + ((((64'sd2176067045*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_41 = -(((64'sd9416918941*P20/E9)*P20)
    + ((((64'sd9416918941*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_42 = -(((64'sd3033200675*P20/E9)*P20)
    + ((((64'sd3033200675*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_50 = ((64'sd1418754402*P20/E12)*P20)
    + ((((64'sd1418754402*P20)%E12)*P20 + E12/2)/E12);
  localparam longint Q_51 = ((64'sd12098588349*P20/E9)*P20)
    + ((((64'sd12098588349*P20)%E9)*P20 + E9/2)/E9);
  localparam longint Q_52 = -(((64'sd2450140197*P20/E9)*P20)
    + ((((64'sd2450140197*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_60 = -(((64'sd14945059732*P20/E12)*P20)
    + ((((64'sd14945059732*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_61 = -(((64'sd79903691631*P20/E9)*P20)
    + ((((64'sd79903691631*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_62 = -(((64'sd4112951591*P20/E9)*P20)
    + ((((64'sd4112951591*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_70 = -(((64'sd8745650800*P20/E12)*P20)
    + ((((64'sd8745650800*P20)%E12)*P20 + E12/2)/E12));
  localparam longint Q_71 = -(((64'sd87907457359*P20/E9)*P20)
    + ((((64'sd87907457359*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_72 = ((64'sd3669245798*P20/E9)*P20)
    + ((((64'sd3669245798*P20)%E9)*P20 + E9/2)/E9);
  localparam longint Q_80 = -(((64'sd139913014949*P20/E9)*P20)
    + ((((64'sd139913014949*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_81 = -(((64'sd263279320156*P20/E9)*P20)
    + ((((64'sd263279320156*P20)%E9)*P20 + E9/2)/E9));
  localparam longint Q_DT = ((64'sd2*P20/E3)*P20)
    + ((((64'sd2*P20)%E3)*P20 + E3/2)/E3);
  localparam longint Q_C0 = ((64'sd1148400*P20/E8)*P20)
    + ((((64'sd1148400*P20)%E8)*P20 + E8/2)/E8);
  localparam longint Q_C1 = -(((64'sd973167*P20/E8)*P20)
    + ((((64'sd973167*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_C2 = ((64'sd504205*P20/E8)*P20)
    + ((((64'sd504205*P20)%E8)*P20 + E8/2)/E8);
  localparam longint Q_C3 = -(((64'sd104432*P20/E8)*P20)
    + ((((64'sd104432*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_C4 = -(((64'sd257534176*P20/E8)*P20)
    + ((((64'sd257534176*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Y1 = -(((64'sd1030994*P20/E8)*P20)
    + ((((64'sd1030994*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Y2 = -(((64'sd517457*P20/E8)*P20)
    + ((((64'sd517457*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Y3 = -(((64'sd115652*P20/E8)*P20)
    + ((((64'sd115652*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Y4 = -(((64'sd226230944*P20/E8)*P20)
    + ((((64'sd226230944*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Z0 = -(((64'sd259115*P20/E8)*P20)
    + ((((64'sd259115*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_Z1 = -(((64'sd44530*P20/E8)*P20)
    + ((((64'sd44530*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_F0 = -(((64'sd42621122*P20/E8)*P20)
    + ((((64'sd42621122*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_F1 = -(((64'sd17307770*P20/E8)*P20)
    + ((((64'sd17307770*P20)%E8)*P20 + E8/2)/E8));
  localparam longint Q_F2 = ((64'sd34335*P20/E5)*P20)
    + ((((64'sd34335*P20)%E5)*P20 + E5/2)/E5);
  // mixer gains carry 20 fraction bits
  localparam longint Q_MA = (64'sd43538837*P20 + E1/2)/E1;
  localparam longint Q_MC = (64'sd334224599*P20 + E1/2)/E1;
  localparam longint Q_MF = (64'sd1436782*P20 + E1/2)/E1;

  function automatic logic signed [63:0] kval(kc_e k);
    logic signed [63:0] v;
    unique case (k)
      K_D2R:  v = Q_D2R;
      K_G:    v = Q_G;
      K_NG:   v = -Q_G;
      K_JX:   v = Q_JX;
      K_JY:   v = Q_JY;
      K_FLOW: v = Q_FLOW;
      K_00:   v = Q_00;
      K_01:   v = Q_01;
      K_02:   v = Q_02;
      K_10:   v = Q_10;
      K_11:   v = Q_11;
      K_12:   v = Q_12;
      K_20:   v = Q_20;
      K_21:   v = Q_21;
      K_30:   v = Q_30;
      K_40:   v = Q_40;
      K_41:   v = Q_41;
      K_42:   v = Q_42;
      K_50:   v = Q_50;
      K_51:   v = Q_51;
      K_52:   v = Q_52;
      K_60:   v = Q_60;
      K_61:   v = Q_61;
      K_62:   v = Q_62;
      K_70:   v = Q_70;
      K_71:   v = Q_71;
      K_72:   v = Q_72;
      K_80:   v = Q_80;
      K_81:   v = Q_81;
      K_DT:   v = Q_DT;
      K_C0:   v = Q_C0;
      K_C1:   v = Q_C1;
      K_C2:   v = Q_C2;
      K_C3:   v = Q_C3;
      K_C4:   v = Q_C4;
      K_Y0:   v = -Q_C0;
      K_Y1:   v = Q_Y1;
      K_Y2:   v = Q_Y2;
      K_Y3:   v = Q_Y3;
      K_Y4:   v = Q_Y4;
      K_Z0:   v = Q_Z0;
      K_Z1:   v = Q_Z1;
      K_F0:   v = Q_F0;
      K_F1:   v = Q_F1;
      K_F2:   v = Q_F2;
      K_MA:   v = Q_MA;
      K_MC:   v = Q_MC;
      K_MF:   v = Q_MF;
      default: v = '0;
    endcase
    return v;
  endfunction

  // control tick microprogram: dst, a, b (field / motor select), constant
  localparam instr_t PROG [PROG_LEN] = '{
    '{OP_LD,  R_GX,  R_ZR,  FLD_GX, K_NONE},
    '{OP_LD,  R_GY,  R_ZR,  FLD_GY, K_NONE},
    '{OP_LD,  R_GZ,  R_ZR,  FLD_GZ, K_NONE},
    '{OP_LD,  R_AZ,  R_ZR,  FLD_AZ, K_NONE},
    '{OP_LD,  R_TGX, R_ZR,  FLD_TX, K_NONE},
    '{OP_LD,  R_TGY, R_ZR,  FLD_TY, K_NONE},
    '{OP_LD,  R_TGZ, R_ZR,  FLD_TZ, K_NONE},
    // rates to rad/s, torque estimates
    '{OP_MUL, R_WX,  R_GX,  R_ZR,  K_D2R},
    '{OP_MUL, R_WY,  R_GY,  R_ZR,  K_D2R},
    '{OP_MUL, R_WZ,  R_GZ,  R_ZR,  K_D2R},
    '{OP_MUL, R_AZG, R_AZ,  R_ZR,  K_G},
    '{OP_SUB, R_T0,  R_WX,  R_PRR, K_NONE},
    '{OP_MUL, R_TQX, R_T0,  R_ZR,  K_JX},
    '{OP_SUB, R_T0,  R_WY,  R_PPR, K_NONE},
    '{OP_MUL, R_TQY, R_T0,  R_ZR,  K_JY},
    '{OP_ADD, R_PRR, R_WX,  R_ZR,  K_NONE},
    '{OP_ADD, R_PPR, R_WY,  R_ZR,  K_NONE},
    // innovations
    '{OP_ADD, R_T0,  R_E6,  R_E6,  K_NONE},
    '{OP_SUB, R_T0,  R_T0,  R_WY,  K_NONE},
    '{OP_MUL, R_T0,  R_T0,  R_ZR,  K_FLOW},
    '{OP_SUB, R_ENX, R_T0,  R_H0,  K_NONE},
    '{OP_ADD, R_T0,  R_E7,  R_E7,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_WX,  K_NONE},
    '{OP_MUL, R_T0,  R_T0,  R_ZR,  K_FLOW},
    '{OP_SUB, R_ENY, R_T0,  R_H1,  K_NONE},
    '{OP_SUB, R_ER,  R_E2,  R_H2,  K_NONE},
    '{OP_SUB, R_EPX, R_E0,  R_H3,  K_NONE},
    '{OP_SUB, R_EPY, R_E1,  R_H4,  K_NONE},
    '{OP_SUB, R_EPZ, R_E2,  R_H5,  K_NONE},
    '{OP_SUB, R_EPS, R_E3,  R_H6,  K_NONE},
    '{OP_SUB, R_ETH, R_E4,  R_H7,  K_NONE},
    '{OP_SUB, R_EPH, R_E5,  R_H8,  K_NONE},
    // derivatives
    '{OP_MUL, R_T1,  R_ENX, R_ZR,  K_00},
    '{OP_ADD, R_D0,  R_E6,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPX, R_ZR,  K_01},
    '{OP_ADD, R_D0,  R_D0,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ETH, R_ZR,  K_02},
    '{OP_ADD, R_D0,  R_D0,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ENY, R_ZR,  K_10},
    '{OP_ADD, R_D1,  R_E7,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPY, R_ZR,  K_11},
    '{OP_ADD, R_D1,  R_D1,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPH, R_ZR,  K_12},
    '{OP_ADD, R_D1,  R_D1,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ER,  R_ZR,  K_20},
    '{OP_ADD, R_D2,  R_E8,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPZ, R_ZR,  K_21},
    '{OP_ADD, R_D2,  R_D2,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPS, R_ZR,  K_30},
    '{OP_ADD, R_D3,  R_WZ,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ENX, R_ZR,  K_40},
    '{OP_ADD, R_D4,  R_WY,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPX, R_ZR,  K_41},
    '{OP_ADD, R_D4,  R_D4,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ETH, R_ZR,  K_42},
    '{OP_ADD, R_D4,  R_D4,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ENY, R_ZR,  K_50},
    '{OP_ADD, R_D5,  R_WX,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPY, R_ZR,  K_51},
    '{OP_ADD, R_D5,  R_D5,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPH, R_ZR,  K_52},
    '{OP_ADD, R_D5,  R_D5,  R_T1,  K_NONE},
    '{OP_MUL, R_D6,  R_E4,  R_ZR,  K_G},
    '{OP_MUL, R_T1,  R_ENX, R_ZR,  K_60},
    '{OP_ADD, R_D6,  R_D6,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPX, R_ZR,  K_61},
    '{OP_ADD, R_D6,  R_D6,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_ETH, R_ZR,  K_62},
    '{OP_ADD, R_D6,  R_D6,  R_T1,  K_NONE},
    '{OP_MUL, R_D7,  R_E5,  R_ZR,  K_NG},
    '{OP_MUL, R_T1,  R_ENY, R_ZR,  K_70},
    '{OP_ADD, R_D7,  R_D7,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPY, R_ZR,  K_71},
    '{OP_ADD, R_D7,  R_D7,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPH, R_ZR,  K_72},
    '{OP_ADD, R_D7,  R_D7,  R_T1,  K_NONE},
    '{OP_KLD, R_T0,  R_ZR,  R_ZR,  K_G},
    '{OP_SUB, R_D8,  R_AZG, R_T0,  K_NONE},
    '{OP_MUL, R_T1,  R_ER,  R_ZR,  K_80},
    '{OP_ADD, R_D8,  R_D8,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_EPZ, R_ZR,  K_81},
    '{OP_ADD, R_D8,  R_D8,  R_T1,  K_NONE},
    // euler step
    '{OP_MUL, R_T1,  R_D0,  R_ZR,  K_DT},
    '{OP_ADD, R_E0,  R_E0,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D1,  R_ZR,  K_DT},
    '{OP_ADD, R_E1,  R_E1,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D2,  R_ZR,  K_DT},
    '{OP_ADD, R_E2,  R_E2,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D3,  R_ZR,  K_DT},
    '{OP_ADD, R_E3,  R_E3,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D4,  R_ZR,  K_DT},
    '{OP_ADD, R_E4,  R_E4,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D5,  R_ZR,  K_DT},
    '{OP_ADD, R_E5,  R_E5,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D6,  R_ZR,  K_DT},
    '{OP_ADD, R_E6,  R_E6,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D7,  R_ZR,  K_DT},
    '{OP_ADD, R_E7,  R_E7,  R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_D8,  R_ZR,  K_DT},
    '{OP_ADD, R_E8,  R_E8,  R_T1,  K_NONE},
    // lqr roll torque
    '{OP_SUB, R_T0,  R_E1,  R_TGY, K_NONE},
    '{OP_MUL, R_TCX, R_T0,  R_ZR,  K_C0},
    '{OP_MUL, R_T1,  R_E5,  R_ZR,  K_C1},
    '{OP_ADD, R_TCX, R_TCX, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_E7,  R_ZR,  K_C2},
    '{OP_ADD, R_TCX, R_TCX, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_WX,  R_ZR,  K_C3},
    '{OP_ADD, R_TCX, R_TCX, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_TQX, R_ZR,  K_C4},
    '{OP_ADD, R_TCX, R_TCX, R_T1,  K_NONE},
    // lqr pitch torque
    '{OP_SUB, R_T0,  R_E0,  R_TGX, K_NONE},
    '{OP_MUL, R_TCY, R_T0,  R_ZR,  K_Y0},
    '{OP_MUL, R_T1,  R_E4,  R_ZR,  K_Y1},
    '{OP_ADD, R_TCY, R_TCY, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_E6,  R_ZR,  K_Y2},
    '{OP_ADD, R_TCY, R_TCY, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_WY,  R_ZR,  K_Y3},
    '{OP_ADD, R_TCY, R_TCY, R_T1,  K_NONE},
    '{OP_MUL, R_T1,  R_TQY, R_ZR,  K_Y4},
    '{OP_ADD, R_TCY, R_TCY, R_T1,  K_NONE},
    // yaw torque and thrust
    '{OP_MUL, R_TZ,  R_E3,  R_ZR,  K_Z0},
    '{OP_MUL, R_T1,  R_WZ,  R_ZR,  K_Z1},
    '{OP_ADD, R_TZ,  R_TZ,  R_T1,  K_NONE},
    '{OP_SUB, R_T0,  R_E2,  R_TGZ, K_NONE},
    '{OP_MUL, R_FZ,  R_T0,  R_ZR,  K_F0},
    '{OP_MUL, R_T1,  R_E8,  R_ZR,  K_F1},
    '{OP_ADD, R_FZ,  R_FZ,  R_T1,  K_NONE},
    '{OP_KLD, R_T1,  R_ZR,  R_ZR,  K_F2},
    '{OP_ADD, R_FZ,  R_FZ,  R_T1,  K_NONE},
    // mixer
    '{OP_MUL20, R_KA, R_TCX, R_ZR, K_MA},
    '{OP_MUL20, R_KB, R_TCY, R_ZR, K_MA},
    '{OP_MUL20, R_KC, R_TZ,  R_ZR, K_MC},
    '{OP_MUL20, R_FZ, R_FZ,  R_ZR, K_MF},
    '{OP_SUB, R_T0,  R_ZR,  R_KA,  K_NONE},
    '{OP_SUB, R_T0,  R_T0,  R_KB,  K_NONE},
    '{OP_SUB, R_T0,  R_T0,  R_KC,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_FZ,  K_NONE},
    '{OP_MOT, R_ZR,  R_T0,  MOT_1, K_NONE},
    '{OP_SUB, R_T0,  R_ZR,  R_KA,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_KB,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_KC,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_FZ,  K_NONE},
    '{OP_MOT, R_ZR,  R_T0,  MOT_2, K_NONE},
    '{OP_ADD, R_T0,  R_KA,  R_KB,  K_NONE},
    '{OP_SUB, R_T0,  R_T0,  R_KC,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_FZ,  K_NONE},
    '{OP_MOT, R_ZR,  R_T0,  MOT_3, K_NONE},
    '{OP_SUB, R_T0,  R_KA,  R_KB,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_KC,  K_NONE},
    '{OP_ADD, R_T0,  R_T0,  R_FZ,  K_NONE},
    '{OP_MOT, R_ZR,  R_T0,  MOT_4, K_NONE},
    '{OP_END, R_ZR,  R_ZR,  R_ZR,  K_NONE}
  };

endpackage

// ===== hdl/quadrotor_observer_lqr_mixer_unit.sv =====
// a store transaction is written in the cycle it is accepted; a control tick runs
// 152 micro-ops, 92 simple ops and 60 products, the products all on the one
// bit-serial multiplier. no new input is taken until the tick's result is in the
// output register.
// a finished result waits in the output register while the next item is taken.
// reset: asynchronous active-low; estimates, held values and rates read as zero.
module quadrotor_observer_lqr_mixer_unit import qolm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // meas_index[3:0], meas_value[35:4], gyro_x[67:36], gyro_y[99:68],
  // gyro_z[131:100], accel_z[163:132], target_x[195:164], target_y[227:196],
  // target_z[259:228], motors_enabled[260], zero pad
  input  logic [263:0] s_axis_tdata_i,
  // opcode[0]
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // motor_one[15:0], motor_two[31:16], motor_three[47:32], motor_four[63:48]
  output logic [63:0]  m_axis_tdata_o
);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_MWAIT, S_DONE} state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic [6:0][31:0] fld_q;
  logic            en_q;
  logic [3:0][15:0] mot_q;
  logic            mvalid_q;
  logic [63:0]     mdata_q;

  instr_t      ins;
  logic [63:0] rda, rdb;
  logic        we;
  ra_t         wa;
  logic [63:0] wd;
  logic        accept;
  logic        store_we;
  logic [64:0] sum;
  logic [63:0] alu;
  mul_ctl_t    mctl;
  logic        mdone;
  logic signed [63:0] mres;

  function automatic logic [63:0] widen(logic [31:0] v);
    return {{8{v[31]}}, v, 24'd0};
  endfunction

  function automatic logic [15:0] to_motor(logic [63:0] v);
    logic [15:0] m;
    if (v[63] || v == 64'd0) begin
      m = 16'd0;
    end else if (|v[62:56]) begin
      m = 16'hFFFF;
    end else begin
      m = v[55:40];
    end
    return m;
  endfunction

  assign ins = PROG[pc_q];

  assign accept   = s_axis_tvalid_i && (state_q == S_IDLE);
  assign store_we = accept && s_axis_tuser_i[0] && (s_axis_tdata_i[3:0] <= 4'd8);

  // saturating add / subtract
  always_comb begin
    if (ins.op == OP_SUB) begin
      sum = {rda[63], rda} - {rdb[63], rdb};
    end else begin
      sum = {rda[63], rda} + {rdb[63], rdb};
    end
    if (sum[64] != sum[63]) begin
      alu = sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      alu = sum[63:0];
    end
  end

  assign mctl.start = (state_q == S_EXEC) && (ins.op == OP_MUL || ins.op == OP_MUL20);
  assign mctl.sh20  = (ins.op == OP_MUL20);

  always_comb begin
    we = 1'b0;
    wa = ins.dst;
    wd = alu;
    priority if (store_we) begin
      we = 1'b1;
      wa = R_H0 + {2'b00, s_axis_tdata_i[3:0]};
      wd = widen(s_axis_tdata_i[35:4]);
    end else if (state_q == S_EXEC) begin
      unique case (ins.op)
        OP_LD: begin
          we = 1'b1;
          wd = widen(fld_q[ins.b[2:0]]);
        end
        OP_KLD: begin
          we = 1'b1;
          wd = kval(ins.k);
        end
        OP_ADD, OP_SUB: we = 1'b1;
        default: we = 1'b0;
      endcase
    end else if (state_q == S_MWAIT && mdone) begin
      we = 1'b1;
      wd = mres;
    end else begin
      we = 1'b0;
    end
  end

  qolm_rf u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ra_i   (ins.a),
    .rb_i   (ins.b),
    .rda_o  (rda),
    .rdb_o  (rdb),
    .we_i   (we),
    .wa_i   (wa),
    .wd_i   (wd)
  );

  qolm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .a_i    (rda),
    .k_i    (kval(ins.k)),
    .done_o (mdone),
    .res_o  (mres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      fld_q    <= '0;
      en_q     <= 1'b0;
      mot_q    <= '0;
      mvalid_q <= 1'b0;
      mdata_q  <= '0;
    end else begin
      if (mvalid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        mvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && !s_axis_tuser_i[0]) begin
            fld_q   <= s_axis_tdata_i[259:36];
            en_q    <= s_axis_tdata_i[260];
            pc_q    <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: state_q <= S_EXEC;
        S_EXEC: begin
          unique case (ins.op)
            OP_MUL, OP_MUL20: state_q <= S_MWAIT;
            OP_END:           state_q <= S_DONE;
            OP_MOT: begin
              mot_q[ins.b[1:0]] <= en_q ? to_motor(rda) : 16'd0;
              pc_q    <= pc_q + 1'b1;
              state_q <= S_FETCH;
            end
            default: begin
              pc_q    <= pc_q + 1'b1;
              state_q <= S_FETCH;
            end
          endcase
        end
        S_MWAIT: begin
          if (mdone) begin
            pc_q    <= pc_q + 1'b1;
            state_q <= S_FETCH;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!mvalid_q || m_axis_tready_i) begin
            mdata_q  <= mot_q;
            mvalid_q <= 1'b1;
            pc_q     <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

endmodule

// ===== hdl/qolm_mul.sv =====
// qolm_mul: bit-serial sign-magnitude multiplier with round-to-nearest
// shift by 40 or 20 and saturation to +-(2^63-1).
// depends on qolm_pkg.
module qolm_mul import qolm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_ctl_t           ctl_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] k_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN, M_NEG} mstate_e;

  mstate_e     state_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic        sh20_q;
  logic [63:0] mcand_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [63:0] mag_q;

  logic [64:0]  sum;
  logic [127:0] prod;
  logic         ovf;
  logic [62:0]  quo;
  logic         rnd;
  logic [63:0]  rounded;

  // one multiplier bit per cycle, lsb first
  assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : 65'd0);
  assign prod = {hi_q, lo_q};

  always_comb begin
    if (sh20_q) begin
      ovf = |prod[127:83];
      quo = prod[82:20];
      rnd = prod[19];
    end else begin
      ovf = |prod[127:103];
      quo = prod[102:40];
      rnd = prod[39];
    end
    rounded = {1'b0, quo} + {63'd0, rnd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      sh20_q  <= 1'b0;
      mcand_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      mag_q   <= '0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          if (ctl_i.start) begin
            neg_q   <= a_i[63] ^ k_i[63];
            sh20_q  <= ctl_i.sh20;
            mcand_q <= a_i[63] ? 64'(-a_i) : a_i;
            lo_q    <= k_i[63] ? 64'(-k_i) : k_i;
            hi_q    <= '0;
            cnt_q   <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          hi_q  <= sum[64:1];
          lo_q  <= {sum[0], lo_q[63:1]};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= M_FIN;
          end
        end
        M_FIN: begin
          mag_q   <= (ovf || rounded[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : rounded;
          state_q <= M_NEG;
        end
        M_NEG: begin
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == M_NEG);
  assign res_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ===== hdl/qolm_rf.sv =====
// qolm_rf: 64 x 64-bit register file, one write and two registered reads;
// entries never written since reset read as zero.
// depends on qolm_pkg.
module qolm_rf import qolm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ra_t         ra_i,
  input  ra_t         rb_i,
  output logic [63:0] rda_o,
  output logic [63:0] rdb_o,
  input  logic        we_i,
  input  ra_t         wa_i,
  input  logic [63:0] wd_i
);

  logic [63:0] mem [64];
  logic [63:0] vld_q;
  logic [63:0] rda_q;
  logic [63:0] rdb_q;
  logic        va_q;
  logic        vb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rda_q <= mem[ra_i];
    rdb_q <= mem[rb_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wa_i] <= 1'b1;
      end
      va_q <= vld_q[ra_i];
      vb_q <= vld_q[rb_i];
    end
  end

  assign rda_o = va_q ? rda_q : 64'd0;
  assign rdb_o = vb_q ? rdb_q : 64'd0;

endmodule

// ===== hdl/qolm_chk.sv =====
// qolm_chk: port-level checks for the observer / lqr / mixer unit,
// bound to the top level. depends on the top level's ports only.
module qolm_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [263:0] s_axis_tdata_i,
  input logic [0:0]   s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a control tick occupies the block
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i[0] |=> !s_axis_tready_o)
    else $error("input taken during a tick");

  // a store completes in its own cycle
  a_store_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] |=> s_axis_tready_o)
    else $error("store did not complete");

  // a new result appears only as the block goes idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result without end of tick");

endmodule

bind quadrotor_observer_lqr_mixer_unit qolm_chk u_qolm_chk (.*);
